/* design/grlb_pkg.sv */
// Package with the shared constants, codes and word types of the rank load balancer.
`timescale 1ns / 1ps
`default_nettype none

package grlb_pkg;

	localparam int NUM_SERVERS = 2;
	localparam int NUM_DIGITS = NUM_SERVERS - 1;
	localparam int IDX_W = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
	localparam int SRV_W = 4;
	localparam int RANK_W = 4;
	localparam int DIGIT_W = 4;
	localparam int LOAD_W = 16;
	localparam int RATIO_W = 5;

	localparam logic [RATIO_W-1:0] RATIO_MIN = 5'd2;
	localparam logic [RATIO_W-1:0] RATIO_MAX = 5'd16;
	localparam logic [RATIO_W-1:0] RATIO_RESET = 5'd4;

	localparam logic OP_REQUEST = 1'b0;
	localparam logic OP_REPLY = 1'b1;

	typedef struct packed {
		logic op;
		logic reply_ok;
		logic [LOAD_W-1:0] reported_load;
	} in_word_t;

	typedef struct packed {
		logic [SRV_W-1:0] chosen_server;
		logic found;
		logic [RANK_W-1:0] rank_used;
	} out_word_t;

endpackage

`default_nettype wire

/* design/geometric_rank_load_balancer.sv */
// Top level of the geometric rank load balancer: server choice and load bookkeeping.
// Usage:
// A command word is taken at a rising edge where start is high and busy is low.
// Busy stays low, so one word can be given in every cycle.
// A request word (op low) always yields one result word; a reply word (op high)
// yields none and returns the pending server with its reported load if reply_ok.
// The command is registered at acceptance, processed in the following cycle, and
// its result is registered in result_q together with done, which is high for exactly one cycle;
// the receiver cannot stall and must take it then.
// Throughput is one word per cycle; the rank selection is a set of parallel load
// comparators over all servers between the command register and result register.
// The ratio register is written through cfg_valid/cfg_ready/cfg_data; cfg_ready
// is always high and writes are expected only while the block is idle.
// Asynchronous reset (arst_n low) sets ratio to 4, all servers present with zero
// load, the request count to zero, and clears the pending server.
`timescale 1ns / 1ps
`default_nettype none

module geometric_rank_load_balancer (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire grlb_pkg::in_word_t cmd,
	output logic done,
	output grlb_pkg::out_word_t result,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [grlb_pkg::RATIO_W-1:0] cfg_data
);

	logic [grlb_pkg::RATIO_W-1:0] ratio_q;
	logic [grlb_pkg::RATIO_W-1:0] ratio_eff;
	logic valid_s1;
	grlb_pkg::in_word_t cmd_s1;
	logic [grlb_pkg::LOAD_W-1:0] load_q [grlb_pkg::NUM_SERVERS];
	logic [grlb_pkg::NUM_SERVERS-1:0] present_q;
	logic [grlb_pkg::SRV_W-1:0] pending_q;
	logic pending_valid_q;
	logic done_q;
	grlb_pkg::out_word_t result_q;
	logic is_req;
	logic is_reply;
	logic [grlb_pkg::RANK_W-1:0] rank;
	logic sel_found;
	logic [grlb_pkg::IDX_W-1:0] sel_idx;
	logic pend_in_range;
	logic [grlb_pkg::IDX_W-1:0] pend_idx;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;
	assign done = done_q;
	assign result = result_q;

	assign ratio_eff = (ratio_q < grlb_pkg::RATIO_MIN) ? grlb_pkg::RATIO_MIN :
		(ratio_q > grlb_pkg::RATIO_MAX) ? grlb_pkg::RATIO_MAX : ratio_q;

	assign is_req = valid_s1 && (cmd_s1.op == grlb_pkg::OP_REQUEST);
	assign is_reply = valid_s1 && (cmd_s1.op == grlb_pkg::OP_REPLY);
	assign pend_in_range = ({1'b0, pending_q} < 5'(grlb_pkg::NUM_SERVERS));
	assign pend_idx = pending_q[grlb_pkg::IDX_W-1:0];

	grlb_counter u_counter (
		.clk(clk),
		.arst_n(arst_n),
		.bump(is_req),
		.ratio_eff(ratio_eff),
		.rank(rank)
	);

	// Each present server counts the present servers ahead of it in load order.
	always_comb begin
		logic [grlb_pkg::RANK_W-1:0] pos;
		sel_found = 1'b0;
		sel_idx = '0;
		for (int s = 0; s < grlb_pkg::NUM_SERVERS; s++) begin
			pos = '0;
			for (int t = 0; t < grlb_pkg::NUM_SERVERS; t++) begin
				if (t != s && present_q[t] && (load_q[t] < load_q[s] ||
					(load_q[t] == load_q[s] && t < s))) begin
					pos = pos + grlb_pkg::RANK_W'(1);
				end
			end
			if (!sel_found && present_q[s] && pos == rank) begin
				sel_found = 1'b1;
				sel_idx = grlb_pkg::IDX_W'(s);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q <= grlb_pkg::RATIO_RESET;
		end else if (cfg_valid && cfg_ready) begin
			ratio_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			done_q <= is_req;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_s1 <= cmd;
		end
		if (is_req) begin
			result_q.chosen_server <= sel_found ? grlb_pkg::SRV_W'(sel_idx) : '0;
			result_q.found <= sel_found;
			result_q.rank_used <= rank;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < grlb_pkg::NUM_SERVERS; s++) begin
				load_q[s] <= '0;
			end
			present_q <= '1;
			pending_q <= '0;
			pending_valid_q <= 1'b0;
		end else if (is_reply) begin
			if (pending_valid_q && cmd_s1.reply_ok && pend_in_range) begin
				load_q[pend_idx] <= cmd_s1.reported_load;
				present_q[pend_idx] <= 1'b1;
			end
			pending_valid_q <= 1'b0;
		end else if (is_req && sel_found) begin
			present_q[sel_idx] <= 1'b0;
			pending_q <= grlb_pkg::SRV_W'(sel_idx);
			pending_valid_q <= 1'b1;
		end
	end

	// A result word appears only for a request processed in the previous cycle.
	a_done_from_request: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(is_req))
		else $error("result word without a request");

	// A chosen server has been taken out of the present set.
	a_chosen_absent: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.found |-> !present_q[result.chosen_server[grlb_pkg::IDX_W-1:0]])
		else $error("chosen server still present");

	// The pending server is never in the present set.
	a_pending_absent: assert property (@(posedge clk) disable iff (!arst_n)
		pending_valid_q |-> !present_q[pend_idx])
		else $error("pending server marked present");

	// A request that found no server reports server zero.
	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.found |-> result.chosen_server == '0)
		else $error("nonzero server without a match");

endmodule

`default_nettype wire

/* design/grlb_counter.sv */
// Request counter held as base-ratio digits; gives the rank after each increment.
`timescale 1ns / 1ps
`default_nettype none

module grlb_counter (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic bump,
	input wire logic [grlb_pkg::RATIO_W-1:0] ratio_eff,
	output logic [grlb_pkg::RANK_W-1:0] rank
);

	logic [grlb_pkg::DIGIT_W-1:0] digit_q [grlb_pkg::NUM_DIGITS];
	logic [grlb_pkg::DIGIT_W-1:0] digit_nx [grlb_pkg::NUM_DIGITS];
	logic [grlb_pkg::NUM_DIGITS:0] carry;
	logic [grlb_pkg::NUM_DIGITS-1:0] wrap;

	always_comb begin
		logic stop;
		carry[0] = 1'b1;
		for (int d = 0; d < grlb_pkg::NUM_DIGITS; d++) begin
			wrap[d] = (({1'b0, digit_q[d]} + 5'd1) >= ratio_eff);
			carry[d+1] = carry[d] & wrap[d];
			if (!carry[d]) begin
				digit_nx[d] = digit_q[d];
			end else if (wrap[d]) begin
				digit_nx[d] = '0;
			end else begin
				digit_nx[d] = digit_q[d] + grlb_pkg::DIGIT_W'(1);
			end
		end
		stop = 1'b0;
		rank = '0;
		for (int d = 0; d < grlb_pkg::NUM_DIGITS; d++) begin
			if (!stop && digit_nx[d] == '0) begin
				rank = rank + grlb_pkg::RANK_W'(1);
			end else begin
				stop = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < grlb_pkg::NUM_DIGITS; d++) begin
				digit_q[d] <= '0;
			end
		end else if (bump) begin
			for (int d = 0; d < grlb_pkg::NUM_DIGITS; d++) begin
				digit_q[d] <= digit_nx[d];
			end
		end
	end

endmodule

`default_nettype wire

/* test/geometric_rank_load_balancer_tb.sv */
// Testbench for the rank load balancer: request and reply words checked against a predictor.
`timescale 1ns / 1ps

module geometric_rank_load_balancer_tb;

	localparam int GAP_MAX = 14;
	localparam int DRAIN_CYCLES = 4;
	localparam int STALL_LIMIT = 400;
	localparam int REPORT_MAX = 10;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	grlb_pkg::in_word_t cmd;
	logic done;
	grlb_pkg::out_word_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [grlb_pkg::RATIO_W-1:0] cfg_data;

	logic [grlb_pkg::RATIO_W-1:0] ratio_reg;
	logic [grlb_pkg::LOAD_W-1:0] load_tab [grlb_pkg::NUM_SERVERS];
	logic present_tab [grlb_pkg::NUM_SERVERS];
	logic [grlb_pkg::DIGIT_W-1:0] digit_tab [grlb_pkg::NUM_DIGITS];
	logic [grlb_pkg::SRV_W-1:0] pend_srv;
	logic pend_ok;
	grlb_pkg::out_word_t pick_q [$];
	int mismatches;
	int stall_cnt;
	bit burst;

	geometric_rank_load_balancer i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic grlb_pkg::in_word_t mk_word(input logic op, input logic ok,
			input logic [grlb_pkg::LOAD_W-1:0] load);
		grlb_pkg::in_word_t w;
		w.op = op;
		w.reply_ok = ok;
		w.reported_load = load;
		return w;
	endfunction

	function automatic logic [grlb_pkg::LOAD_W-1:0] rand_load();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			2: return grlb_pkg::LOAD_W'($urandom_range(0, 3));
			default: return grlb_pkg::LOAD_W'($urandom);
		endcase
	endfunction

	task automatic reset_balancer_model();
		ratio_reg = grlb_pkg::RATIO_RESET;
		for (int i = 0; i < grlb_pkg::NUM_SERVERS; i++) begin
			load_tab[i] = '0;
			present_tab[i] = 1'b1;
		end
		for (int d = 0; d < grlb_pkg::NUM_DIGITS; d++) begin
			digit_tab[d] = '0;
		end
		pend_srv = '0;
		pend_ok = 1'b0;
	endtask

	task automatic predict_pick(input grlb_pkg::in_word_t w);
		int eff;
		int zeros;
		int pos;
		logic carry;
		logic stop;
		grlb_pkg::out_word_t pick;
		eff = (ratio_reg < grlb_pkg::RATIO_MIN) ? int'(grlb_pkg::RATIO_MIN) :
			(ratio_reg > grlb_pkg::RATIO_MAX) ? int'(grlb_pkg::RATIO_MAX) : int'(ratio_reg);
		if (w.op == grlb_pkg::OP_REPLY) begin
			if (pend_ok && w.reply_ok && pend_srv < grlb_pkg::NUM_SERVERS) begin
				load_tab[pend_srv] = w.reported_load;
				present_tab[pend_srv] = 1'b1;
			end
			pend_ok = 1'b0;
		end else begin
			carry = 1'b1;
			for (int d = 0; d < grlb_pkg::NUM_DIGITS; d++) begin
				if (carry) begin
					if (int'(digit_tab[d]) + 1 >= eff) begin
						digit_tab[d] = '0;
					end else begin
						digit_tab[d] = digit_tab[d] + 1'b1;
						carry = 1'b0;
					end
				end
			end
			zeros = 0;
			stop = 1'b0;
			for (int d = 0; d < grlb_pkg::NUM_DIGITS; d++) begin
				if (!stop) begin
					if (digit_tab[d] != '0) stop = 1'b1;
					else zeros++;
				end
			end
			pick = '0;
			pick.rank_used = grlb_pkg::RANK_W'(zeros);
			for (int s = 0; s < grlb_pkg::NUM_SERVERS; s++) begin
				if (!pick.found && present_tab[s]) begin
					pos = 0;
					for (int t = 0; t < grlb_pkg::NUM_SERVERS; t++) begin
						if (t != s && present_tab[t] && (load_tab[t] < load_tab[s] ||
								(load_tab[t] == load_tab[s] && t < s))) pos++;
					end
					if (pos == zeros) begin
						pick.found = 1'b1;
						pick.chosen_server = grlb_pkg::SRV_W'(s);
					end
				end
			end
			if (pick.found) begin
				present_tab[pick.chosen_server] = 1'b0;
				pend_srv = pick.chosen_server;
				pend_ok = 1'b1;
			end
			pick_q = {pick_q, pick};
		end
	endtask

	task automatic send_word(input grlb_pkg::in_word_t w);
		int gap;
		if ($urandom_range(0, 31) == 0) burst = !burst;
		gap = burst ? 0 : $urandom_range(0, GAP_MAX);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= w;
		do @(posedge clk); while (busy);
		predict_pick(w);
	endtask

	task automatic send_pair();
		send_word(mk_word(grlb_pkg::OP_REQUEST, 1'($urandom),
			grlb_pkg::LOAD_W'($urandom)));
		send_word(mk_word(grlb_pkg::OP_REPLY, 1'b1, rand_load()));
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pick_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_ratio(input logic [grlb_pkg::RATIO_W-1:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		ratio_reg = v;
	endtask

	task automatic test_directed();
		send_word(mk_word(grlb_pkg::OP_REQUEST, 1'b1, 16'hFFFF));
		send_word(mk_word(grlb_pkg::OP_REPLY, 1'b1, 16'hFFFF));
		send_word(mk_word(grlb_pkg::OP_REQUEST, 1'b0, 16'h0000));
		send_word(mk_word(grlb_pkg::OP_REPLY, 1'b1, 16'hFFFF));
		send_word(mk_word(grlb_pkg::OP_REQUEST, 1'b1, 16'h0000));
		send_word(mk_word(grlb_pkg::OP_REPLY, 1'b1, 16'h0005));
		send_word(mk_word(grlb_pkg::OP_REQUEST, 1'b0, 16'h8000));
		send_word(mk_word(grlb_pkg::OP_REPLY, 1'b1, 16'h0000));
		send_word(mk_word(grlb_pkg::OP_REPLY, 1'b1, 16'h1234));
		send_word(mk_word(grlb_pkg::OP_REPLY, 1'b0, 16'hFFFF));
	endtask

	task automatic test_ratio_sweep();
		logic [grlb_pkg::RATIO_W-1:0] sweep [11];
		sweep = '{grlb_pkg::RATIO_MIN, grlb_pkg::RATIO_MAX, 5'd0, 5'd1, 5'd17, 5'd31,
			5'd3, 5'd9, grlb_pkg::RATIO_MAX, grlb_pkg::RATIO_MIN,
			grlb_pkg::RATIO_W'($urandom)};
		foreach (sweep[k]) begin
			write_ratio(sweep[k]);
			repeat (10) send_pair();
		end
	endtask

	task automatic test_random_pairs();
		for (int n = 0; n < 90; n++) begin
			if ($urandom_range(0, 15) == 0) drain();
			if ($urandom_range(0, 24) == 0) begin
				write_ratio(grlb_pkg::RATIO_W'($urandom_range(0, 31)));
			end
			send_pair();
		end
	endtask

	task automatic test_broken_sequences();
		write_ratio(grlb_pkg::RATIO_MIN);
		send_word(mk_word(grlb_pkg::OP_REQUEST, 1'b0, 16'h0000));
		send_word(mk_word(grlb_pkg::OP_REQUEST, 1'b1, 16'hFFFF));
		send_word(mk_word(grlb_pkg::OP_REPLY, 1'b1, 16'h0007));
		repeat (3) send_pair();
		send_word(mk_word(grlb_pkg::OP_REQUEST, 1'b0, 16'h0000));
		send_word(mk_word(grlb_pkg::OP_REPLY, 1'b0, 16'h00FF));
		send_word(mk_word(grlb_pkg::OP_REQUEST, 1'b1, 16'h0001));
		send_word(mk_word(grlb_pkg::OP_REQUEST, 1'b0, 16'hFFFE));
	endtask

	task automatic test_random_noise();
		for (int n = 0; n < 60; n++) begin
			if ($urandom_range(0, 19) == 0) write_ratio(grlb_pkg::RATIO_W'($urandom));
			send_word(mk_word(1'($urandom), 1'($urandom), rand_load()));
		end
	endtask

	task automatic report_mismatch(input string what, input grlb_pkg::out_word_t want,
			input grlb_pkg::out_word_t got);
		mismatches++;
		if (mismatches <= REPORT_MAX) begin
			$display("%s: expected server %0d found %0d rank %0d, %s %0d found %0d rank %0d",
				what, want.chosen_server, want.found, want.rank_used, "got server",
				got.chosen_server, got.found, got.rank_used);
		end
	endtask

	always @(posedge clk) begin
		grlb_pkg::out_word_t want;
		if (arst_n && done) begin
			if (pick_q.size() == 0) begin
				report_mismatch("Result word with nothing expected", '0, result);
			end else begin
				want = pick_q.pop_front();
				if (result.chosen_server !== want.chosen_server ||
						result.found !== want.found ||
						result.rank_used !== want.rank_used) begin
					report_mismatch("Result word mismatch", want, result);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
			stall_cnt <= 0;
		end else if (stall_cnt >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			stall_cnt <= stall_cnt + 1;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		cfg_valid = 1'b0;
		cfg_data = grlb_pkg::RATIO_RESET;
		burst = 1'b0;
		reset_balancer_model();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_ratio_sweep();
		test_random_pairs();
		test_broken_sequences();
		test_random_noise();
		drain();
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

/* files.f */
design/grlb_pkg.sv
design/grlb_counter.sv
design/geometric_rank_load_balancer.sv
test/geometric_rank_load_balancer_tb.sv
